### src/tep_pkg.sv
// Package for the tree entry parser: payload structs, command and phase codes,
// hash size constants and the hex character function.
// Depends on nothing; every other file in src uses it by scoped names.
package tep_pkg;

    localparam int HASH_BYTES = 20;
    localparam int HASH_IDX_W = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;

    localparam int MODE_W = 20;
    localparam logic [MODE_W-1:0] MODE_MAX = 20'd999999;
    localparam logic [MODE_W-1:0] DIR_MODE = 20'd40000;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_NAME     = 2'd0,
        KIND_HASH     = 2'd1,
        KIND_FMT_ERR  = 2'd2,
        KIND_TRUNC    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_MODE  = 2'd1,
        PH_NAME  = 2'd2,
        PH_HASH  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_object;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        text_first;
        logic [7:0]        text_second;
        logic              entry_done;
        logic [MODE_W-1:0] mode_value;
        logic              is_directory;
    } out_item_t;

    // One classified byte on its way from the front to the back.
    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data_byte;
        logic              entry_done;
        logic [MODE_W-1:0] mode;
    } cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'b0, nib};
        end else begin
            c = 8'h57 + {4'b0, nib};
        end
        return c;
    endfunction

endpackage

### src/tep_front.sv
// Front end of the tree entry parser: tracks the entry phase, accumulates the
// mode and classifies each accepted byte into a command for the back end.
// Depends on tep_pkg.
module tep_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  tep_pkg::in_item_t in_item,
    output logic              push,
    output tep_pkg::cmd_t     cmd
);

    localparam int IdxW = tep_pkg::HASH_IDX_W;
    localparam logic [IdxW-1:0] HashLast = IdxW'(tep_pkg::HASH_BYTES - 1);

    tep_pkg::phase_t phase_reg, phase_next;
    logic [tep_pkg::MODE_W-1:0] acc_reg, acc_next;
    logic junk_reg, junk_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic failed_reg, failed_next;

    logic [7:0] b;
    logic       is_digit;
    logic [23:0] acc_wide;
    logic [23:0] prod;
    logic [tep_pkg::MODE_W-1:0] acc_sat;
    logic       result;

    assign b        = in_item.data_byte;
    assign is_digit = (b >= tep_pkg::CHAR_ZERO) && (b <= tep_pkg::CHAR_NINE);
    assign acc_wide = {4'b0, acc_reg};
    assign prod     = (acc_wide << 3) + (acc_wide << 1) + {16'b0, b - tep_pkg::CHAR_ZERO};
    assign acc_sat  = (prod > {4'b0, tep_pkg::MODE_MAX}) ? tep_pkg::MODE_MAX
                                                         : prod[tep_pkg::MODE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= tep_pkg::PH_START;
            acc_reg    <= '0;
            junk_reg   <= 1'b0;
            idx_reg    <= '0;
            failed_reg <= 1'b0;
        end else if (in_fire) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            junk_reg   <= junk_next;
            idx_reg    <= idx_next;
            failed_reg <= failed_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        junk_next      = junk_reg;
        idx_next       = idx_reg;
        failed_next    = failed_reg;
        result         = 1'b0;
        cmd.kind       = tep_pkg::KIND_NAME;
        cmd.data_byte  = b;
        cmd.entry_done = 1'b0;
        cmd.mode       = '0;

        if (!failed_reg) begin
            unique case (phase_reg) inside
                tep_pkg::PH_START, tep_pkg::PH_MODE: begin
                    if (b == tep_pkg::CHAR_SPACE) begin
                        if (acc_reg == '0 && junk_reg) begin
                            // An all-junk mode cannot be recovered; drop the rest.
                            result      = 1'b1;
                            cmd.kind    = tep_pkg::KIND_FMT_ERR;
                            failed_next = 1'b1;
                        end else begin
                            phase_next = tep_pkg::PH_NAME;
                        end
                    end else begin
                        phase_next = tep_pkg::PH_MODE;
                        if (is_digit && !junk_reg) begin
                            acc_next = acc_sat;
                        end else begin
                            junk_next = 1'b1;
                        end
                    end
                end
                tep_pkg::PH_NAME: begin
                    if (b == tep_pkg::CHAR_NUL) begin
                        phase_next = tep_pkg::PH_HASH;
                        idx_next   = '0;
                    end else begin
                        result = 1'b1;
                    end
                end
                tep_pkg::PH_HASH: begin
                    result   = 1'b1;
                    cmd.kind = tep_pkg::KIND_HASH;
                    if (idx_reg == HashLast) begin
                        cmd.entry_done = 1'b1;
                        cmd.mode       = acc_reg;
                        phase_next     = tep_pkg::PH_START;
                        acc_next       = '0;
                        junk_next      = 1'b0;
                        idx_next       = '0;
                    end else begin
                        idx_next = idx_reg + IdxW'(1);
                    end
                end
                default: begin
                    phase_next = tep_pkg::PH_START;
                end
            endcase
        end

        if (in_item.end_of_object) begin
            // An object that stops mid-entry is reported as truncated, unless a format
            // error was already raised in this object, by this byte or an earlier one.
            if (!failed_next && phase_next != tep_pkg::PH_START) begin
                result         = 1'b1;
                cmd.kind       = tep_pkg::KIND_TRUNC;
                cmd.data_byte  = '0;
                cmd.entry_done = 1'b0;
                cmd.mode       = '0;
            end
            phase_next  = tep_pkg::PH_START;
            acc_next    = '0;
            junk_next   = 1'b0;
            idx_next    = '0;
            failed_next = 1'b0;
        end

        if (failed_reg) begin
            result = 1'b0;
        end
    end

    assign push = in_fire && result;

endmodule

### src/tep_queue.sv
// Short command queue between the front and back ends of the tree entry parser.
// Depends on tep_pkg.
module tep_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tep_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output tep_pkg::cmd_t head_cmd
);

    localparam int PtrW = tep_pkg::QUEUE_PTR_W;
    localparam int CntW = tep_pkg::QUEUE_PTR_W + 1;
    localparam logic [CntW-1:0] Depth = CntW'(tep_pkg::QUEUE_DEPTH);

    tep_pkg::cmd_t slot_reg [tep_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full     = (count_reg == Depth);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CntW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/tep_back.sv
// Back end of the tree entry parser: turns queued commands into result items
// (hex conversion, directory check) and holds them in the output register.
// Depends on tep_pkg.
module tep_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_avail,
    input  tep_pkg::cmd_t      cmd,
    output logic               cmd_take,
    output logic               m_valid,
    input  logic               m_ready,
    output tep_pkg::out_item_t m_data
);

    logic               valid_reg;
    tep_pkg::out_item_t data_reg, data_next;

    assign cmd_take = cmd_avail && (!valid_reg || m_ready);
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_comb begin
        data_next.kind         = cmd.kind;
        data_next.text_first   = '0;
        data_next.text_second  = '0;
        data_next.entry_done   = cmd.entry_done;
        data_next.mode_value   = cmd.mode;
        data_next.is_directory = cmd.entry_done && (cmd.mode == tep_pkg::DIR_MODE);
        unique case (cmd.kind)
            tep_pkg::KIND_NAME: begin
                data_next.text_first = cmd.data_byte;
            end
            tep_pkg::KIND_HASH: begin
                data_next.text_first  = tep_pkg::hex_char(cmd.data_byte[7:4]);
                data_next.text_second = tep_pkg::hex_char(cmd.data_byte[3:0]);
            end
            default: begin
                data_next.text_first = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd_take) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_take) begin
            data_reg <= data_next;
        end
    end

endmodule

### src/tree_entry_parser.sv
// Tree entry parser: one tree object byte in per cycle, at most one result item
// out per byte. A result item reaches m_valid from its accepted byte through
// the front end, the four-entry command queue and the output register.
// Sustained rate is one byte per cycle; s_ready drops only while the command
// queue is full because the result side is stalled.
// aresetn is synchronous and active low and returns the parser to the start of an entry.
module tree_entry_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tep_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tep_pkg::out_item_t m_data
);

    logic          in_fire;
    logic          push;
    tep_pkg::cmd_t push_cmd;
    logic          full;
    logic          empty;
    logic          pop;
    tep_pkg::cmd_t head_cmd;

    assign s_ready = !full;
    assign in_fire = s_valid && s_ready;

    tep_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_item (s_data),
        .push    (push),
        .cmd     (push_cmd)
    );

    tep_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head_cmd (head_cmd)
    );

    tep_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_avail (!empty),
        .cmd       (head_cmd),
        .cmd_take  (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
